// ----- hw/rtl/c_subset_lexer_macros.svh -----
// Assertion macros shared by the lexer RTL.
`ifndef C_SUBSET_LEXER_MACROS_SVH
`define C_SUBSET_LEXER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CSL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lexer assertion failed");

// antecedent implies consequent in the next cycle
`define CSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexer assertion failed");

`endif

// ----- hw/rtl/csl_pkg.sv -----
// Types, constants and per-byte lexing functions of the C subset lexer.
package csl_pkg;

   localparam int MaxLexemeLen = 128;
   localparam int LenCapInt    = (MaxLexemeLen - 1) > 127 ? 127 : (MaxLexemeLen - 1);
   localparam logic [6:0] LenCap = 7'(LenCapInt);
   localparam int NumKw        = 14;
   localparam int MaxResults   = 4;
   localparam int FifoDepth    = 8;

   localparam logic [3:0] KindKeyword  = 4'd0;
   localparam logic [3:0] KindIdent    = 4'd1;
   localparam logic [3:0] KindInt      = 4'd2;
   localparam logic [3:0] KindFloat    = 4'd3;
   localparam logic [3:0] KindString   = 4'd4;
   localparam logic [3:0] KindChar     = 4'd5;
   localparam logic [3:0] KindOp       = 4'd6;
   localparam logic [3:0] KindSym      = 4'd7;
   localparam logic [3:0] KindErrStr   = 4'd8;
   localparam logic [3:0] KindErrChar  = 4'd9;
   localparam logic [3:0] KindErrByte  = 4'd10;
   localparam logic [3:0] KindEnd      = 4'd11;

   localparam logic [2:0] StripNormal = 3'd0;
   localparam logic [2:0] StripSlash  = 3'd1;
   localparam logic [2:0] StripLine   = 3'd2;
   localparam logic [2:0] StripBlock  = 3'd3;
   localparam logic [2:0] StripStar   = 3'd4;

   localparam logic [2:0] LexIdle  = 3'd0;
   localparam logic [2:0] LexIdent = 3'd1;
   localparam logic [2:0] LexNum   = 3'd2;
   localparam logic [2:0] LexStr   = 3'd3;
   localparam logic [2:0] LexCa    = 3'd4;
   localparam logic [2:0] LexCb    = 3'd5;
   localparam logic [2:0] LexCc    = 3'd6;
   localparam logic [2:0] LexSkip  = 3'd7;

   localparam logic [7:0] ChNewline = 8'h0a;
   localparam logic [7:0] ChQuote   = 8'h22;
   localparam logic [7:0] ChTick    = 8'h27;
   localparam logic [7:0] ChStar    = 8'h2a;
   localparam logic [7:0] ChDot     = 8'h2e;
   localparam logic [7:0] ChSlash   = 8'h2f;
   localparam logic [7:0] ChBslash  = 8'h5c;
   localparam logic [7:0] ChUnder   = 8'h5f;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] line_number;
      logic [31:0] start_offset;
      logic [6:0]  lexeme_length;
      logic [3:0]  keyword_index;
      logic [7:0]  first_char;
      logic [7:0]  second_char;
      logic        too_long;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] line;
      logic [31:0] tstart;
      logic [6:0]  tlen;
      logic [13:0] cand;
      logic        dec;
      logic [7:0]  held0;
      logic [7:0]  held1;
      logic        over;
   } lex_state_type;

   typedef struct packed {
      lex_state_type st;
      logic [1:0]    cnt;
      rsp_type       r0;
      rsp_type       r1;
   } lex_out_type;

   function automatic logic [3:0] kw_len(input logic [3:0] k);
      case (k)
         4'd0: kw_len = 4'd3;   4'd1: kw_len = 4'd5;   4'd2: kw_len = 4'd4;
         4'd3: kw_len = 4'd6;   4'd4: kw_len = 4'd4;   4'd5: kw_len = 4'd2;
         4'd6: kw_len = 4'd4;   4'd7: kw_len = 4'd5;   4'd8: kw_len = 4'd3;
         4'd9: kw_len = 4'd2;   4'd10: kw_len = 4'd6;  4'd11: kw_len = 4'd4;
         4'd12: kw_len = 4'd5;  4'd13: kw_len = 4'd8;
         default: kw_len = 4'd0;
      endcase
   endfunction

   function automatic logic [63:0] kw_text(input logic [3:0] k);
      case (k)
         4'd0: kw_text = 64'("tni");
         4'd1: kw_text = 64'("taolf");
         4'd2: kw_text = 64'("rahc");
         4'd3: kw_text = 64'("nruter");
         4'd4: kw_text = 64'("diov");
         4'd5: kw_text = 64'("fi");
         4'd6: kw_text = 64'("esle");
         4'd7: kw_text = 64'("elihw");
         4'd8: kw_text = 64'("rof");
         4'd9: kw_text = 64'("od");
         4'd10: kw_text = 64'("hctiws");
         4'd11: kw_text = 64'("esac");
         4'd12: kw_text = 64'("kaerb");
         4'd13: kw_text = 64'("eunitnoc");
         default: kw_text = '0;
      endcase
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      is_alpha = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      is_op = c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h2f || c == 8'h25 ||
              c == 8'h3d || c == 8'h3c || c == 8'h3e || c == 8'h26 || c == 8'h7c ||
              c == 8'h21 || c == 8'h5e;
   endfunction

   function automatic logic is_sym(input logic [7:0] c);
      is_sym = c == 8'h28 || c == 8'h29 || c == 8'h7b || c == 8'h7d ||
               c == 8'h2c || c == 8'h3b;
   endfunction

   function automatic rsp_type mk_rsp(input logic [3:0] kind, input logic [15:0] line,
                                      input logic [31:0] start, input logic [6:0] len,
                                      input logic [3:0] kwi, input logic [7:0] c1,
                                      input logic [7:0] c2, input logic over);
      rsp_type r;
      r.token_kind    = kind;
      r.line_number   = line;
      r.start_offset  = start;
      r.lexeme_length = len;
      r.keyword_index = kwi;
      r.first_char    = c1;
      r.second_char   = c2;
      r.too_long      = over;
      r.last_result   = 1'b0;
      return r;
   endfunction

   function automatic lex_state_type grow(input lex_state_type s);
      lex_state_type n;
      n = s;
      if (s.tlen < LenCap) n.tlen = s.tlen + 7'd1;
      else n.over = 1'b1;
      return n;
   endfunction

   function automatic lex_state_type begin_tok(input lex_state_type s,
                                               input logic [31:0] off,
                                               input logic [2:0] mode);
      lex_state_type n;
      n = s;
      n.tstart = off;
      n.tlen   = '0;
      n.over   = 1'b0;
      n.cand   = '1;
      n.dec    = 1'b0;
      n.mode   = mode;
      return n;
   endfunction

   function automatic lex_state_type add_ident(input lex_state_type s, input logic [7:0] c);
      lex_state_type n;
      logic [63:0]   t;
      n = s;
      for (int k = 0; k < NumKw; k++) begin
         t = kw_text(4'(k));
         if (s.tlen >= 7'(kw_len(4'(k))) || t[s.tlen[2:0]*8 +: 8] != c)
            n.cand[k] = 1'b0;
      end
      return grow(n);
   endfunction

   function automatic rsp_type flush_word(input lex_state_type s);
      logic       hit;
      logic [3:0] kwi;
      hit = 1'b0;
      kwi = '0;
      for (int k = NumKw - 1; k >= 0; k--) begin
         if (s.cand[k] && 7'(kw_len(4'(k))) == s.tlen && !s.over) begin
            hit = 1'b1;
            kwi = 4'(k);
         end
      end
      if (s.mode == LexIdent) begin
         if (hit) return mk_rsp(KindKeyword, s.line, s.tstart, s.tlen, kwi, '0, '0, 1'b0);
         return mk_rsp(KindIdent, s.line, s.tstart, s.tlen, '0, '0, '0, s.over);
      end
      return mk_rsp(s.dec ? KindFloat : KindInt, s.line, s.tstart, s.tlen, '0, '0, '0,
                    s.over);
   endfunction

   function automatic lex_out_type lex_idle(input lex_state_type s, input logic [7:0] c,
                                            input logic [31:0] off);
      lex_out_type o;
      o = '0;
      o.st = s;
      if (is_space(c)) begin
         if (c == ChNewline && s.line != 16'hffff) o.st.line = s.line + 16'd1;
      end else if (is_alpha(c) || c == ChUnder) begin
         o.st = add_ident(begin_tok(s, off, LexIdent), c);
      end else if (is_digit(c)) begin
         o.st = grow(begin_tok(s, off, LexNum));
      end else if (c == ChQuote) begin
         o.st = begin_tok(s, off, LexStr);
      end else if (c == ChTick) begin
         o.st = begin_tok(s, off, LexCa);
      end else begin
         o.cnt = 2'd1;
         o.r0  = mk_rsp(is_op(c) ? KindOp : (is_sym(c) ? KindSym : KindErrByte),
                        s.line, off, 7'd1, '0, c, '0, 1'b0);
      end
      return o;
   endfunction

   function automatic lex_out_type flush_then_idle(input lex_state_type s,
                                                   input logic [7:0] c,
                                                   input logic [31:0] off);
      lex_out_type o;
      lex_out_type i;
      lex_state_type t;
      t = s;
      t.mode = LexIdle;
      i = lex_idle(t, c, off);
      o = '0;
      o.st  = i.st;
      o.r0  = flush_word(s);
      o.r1  = i.r0;
      o.cnt = 2'd1 + i.cnt;
      return o;
   endfunction

   function automatic lex_out_type lex_char(input lex_state_type s, input logic [7:0] c,
                                            input logic [31:0] off);
      lex_out_type o;
      lex_out_type i;
      lex_state_type t;
      o = '0;
      o.st = s;
      t = s;
      t.mode = LexIdle;
      case (s.mode)
         LexIdent: begin
            if (is_alpha(c) || is_digit(c) || c == ChUnder) o.st = add_ident(s, c);
            else o = flush_then_idle(s, c, off);
         end
         LexNum: begin
            if (is_digit(c) || (c == ChDot && !s.dec)) begin
               o.st = grow(s);
               if (c == ChDot) o.st.dec = 1'b1;
            end else begin
               o = flush_then_idle(s, c, off);
            end
         end
         LexStr: begin
            if (c == ChQuote) begin
               o.cnt = 2'd1;
               o.r0  = mk_rsp(KindString, s.line, s.tstart, s.tlen, '0, '0, '0, s.over);
               o.st  = t;
            end else begin
               o.st = grow(s);
            end
         end
         LexCa: begin
            o.st.held0 = c;
            o.st.mode  = LexCb;
         end
         LexCb: begin
            if (c == ChTick) begin
               o.cnt = 2'd1;
               o.r0  = mk_rsp(KindChar, s.line, s.tstart, 7'd1, '0, s.held0, '0, 1'b0);
               o.st  = t;
            end else if (s.held0 == ChBslash) begin
               o.st.held1 = c;
               o.st.mode  = LexCc;
            end else if (s.held0 == ChTick) begin
               i = lex_idle(t, c, off);
               o.st  = i.st;
               o.r0  = mk_rsp(KindErrChar, s.line, s.tstart, '0, '0, '0, '0, 1'b0);
               o.r1  = i.r0;
               o.cnt = 2'd1 + i.cnt;
            end else begin
               o.cnt = 2'd1;
               o.r0  = mk_rsp(KindErrChar, s.line, s.tstart, '0, '0, '0, '0, 1'b0);
               o.st.mode = LexSkip;
            end
         end
         LexCc: begin
            o.cnt = 2'd1;
            if (c == ChTick) begin
               o.r0 = mk_rsp(KindChar, s.line, s.tstart, 7'd2, '0, ChBslash, s.held1, 1'b0);
               o.st = t;
            end else begin
               o.r0 = mk_rsp(KindErrChar, s.line, s.tstart, '0, '0, '0, '0, 1'b0);
               o.st.mode = LexSkip;
            end
         end
         LexSkip: begin
            if (c == ChTick) o.st = t;
         end
         default: begin
            o = lex_idle(t, c, off);
         end
      endcase
      return o;
   endfunction

   function automatic lex_out_type lex_end(input lex_state_type s, input logic [31:0] soff);
      lex_out_type o;
      o = '0;
      o.st = s;
      o.st.mode = LexIdle;
      o.r1 = mk_rsp(KindEnd, s.line, soff, '0, '0, '0, '0, 1'b0);
      o.cnt = 2'd1;
      if (s.mode == LexIdent || s.mode == LexNum) begin
         o.r0 = flush_word(s);
         o.cnt = 2'd2;
      end else if (s.mode == LexStr) begin
         o.r0 = mk_rsp(KindErrStr, s.line, s.tstart, '0, '0, '0, '0, 1'b0);
         o.cnt = 2'd2;
      end else if (s.mode == LexCa || s.mode == LexCb || s.mode == LexCc) begin
         o.r0 = mk_rsp(KindErrChar, s.line, s.tstart, '0, '0, '0, '0, 1'b0);
         o.cnt = 2'd2;
      end
      if (o.cnt == 2'd1) o.r0 = o.r1;
      return o;
   endfunction

endpackage

// ----- hw/rtl/c_subset_lexer.sv -----
// C subset lexer top level: comment stripper, lexer state and result queue.
//
//   channel | direction | payload               | handshake
//   req     | in        | csl_pkg::req_type     | req_valid / req_ready
//   rsp     | out       | csl_pkg::rsp_type     | rsp_valid / rsp_ready
//
// One byte is taken per cycle while req_ready is high; its zero to four results
// enter an eight-entry queue in the same edge and leave it one per cycle on rsp_ready.
// req_ready is high while the queue has room for four results.
// One byte per cycle is sustained if results average one per byte and rsp_ready is high.
// Reset clears all lexer state and the queue; an end result clears the lexer state only.
`include "c_subset_lexer_macros.svh"

module c_subset_lexer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  csl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output csl_pkg::rsp_type rsp_data
);

   csl_pkg::lex_state_type lex_ff, lex_in, lex_rst;
   logic [2:0]  strip_ff, strip_in;
   logic [31:0] soff_ff, soff_in;
   csl_pkg::rsp_type fifo_ff [csl_pkg::FifoDepth];
   logic [2:0]  wptr_ff, rptr_ff;
   logic [3:0]  count_ff, count_in;

   csl_pkg::lex_out_type o1, o2, oe;
   csl_pkg::rsp_type res [csl_pkg::MaxResults];
   logic [2:0]  nres;
   logic        acc, pop, endf, call1, call2;
   logic [7:0]  c, ch1;
   logic [31:0] off1;
   logic [2:0]  strip_mid;
   csl_pkg::lex_state_type s1, s2;

   always_comb begin
      lex_rst        = '0;
      lex_rst.mode   = csl_pkg::LexIdle;
      lex_rst.line   = 16'd1;
      lex_rst.cand   = '1;
   end

   assign acc  = req_valid && req_ready;
   assign pop  = rsp_valid && rsp_ready;
   assign c    = req_data.text_byte;
   assign endf = (c == 8'h00) || req_data.end_of_text;

   always_comb begin
      call1     = 1'b0;
      call2     = 1'b0;
      ch1       = c;
      off1      = soff_ff;
      strip_mid = strip_ff;
      if (c != 8'h00) begin
         case (strip_ff)
            csl_pkg::StripSlash: begin
               if (c == csl_pkg::ChSlash) strip_mid = csl_pkg::StripLine;
               else if (c == csl_pkg::ChStar) strip_mid = csl_pkg::StripBlock;
               else begin
                  strip_mid = csl_pkg::StripNormal;
                  call1 = 1'b1;
                  ch1   = csl_pkg::ChSlash;
                  off1  = soff_ff - 32'd1;
                  call2 = 1'b1;
               end
            end
            csl_pkg::StripLine: begin
               if (c == csl_pkg::ChNewline) begin
                  strip_mid = csl_pkg::StripNormal;
                  call1 = 1'b1;
               end
            end
            csl_pkg::StripBlock: begin
               if (c == csl_pkg::ChStar) strip_mid = csl_pkg::StripStar;
            end
            csl_pkg::StripStar: begin
               if (c == csl_pkg::ChSlash) strip_mid = csl_pkg::StripNormal;
               else if (c != csl_pkg::ChStar) strip_mid = csl_pkg::StripBlock;
            end
            default: begin
               if (c == csl_pkg::ChSlash) strip_mid = csl_pkg::StripSlash;
               else begin
                  strip_mid = csl_pkg::StripNormal;
                  call1 = 1'b1;
               end
            end
         endcase
      end
      soff_in = soff_ff + {31'd0, c != 8'h00};
      if (endf && strip_mid == csl_pkg::StripSlash) begin
         call1 = 1'b1;
         ch1   = csl_pkg::ChSlash;
         off1  = soff_in - 32'd1;
      end
   end

   always_comb begin
      o1 = csl_pkg::lex_char(lex_ff, ch1, off1);
      s1 = call1 ? o1.st : lex_ff;
      o2 = csl_pkg::lex_char(s1, c, soff_ff);
      s2 = call2 ? o2.st : s1;
      oe = csl_pkg::lex_end(s2, soff_in);
   end

   always_comb begin
      for (int i = 0; i < csl_pkg::MaxResults; i++) res[i] = '0;
      nres = '0;
      if (call1 && o1.cnt != 2'd0) begin
         res[nres[1:0]] = o1.r0;
         nres = nres + 3'd1;
      end
      if (call1 && o1.cnt == 2'd2) begin
         res[nres[1:0]] = o1.r1;
         nres = nres + 3'd1;
      end
      if (call2 && o2.cnt != 2'd0 && nres < 3'd4) begin
         res[nres[1:0]] = o2.r0;
         nres = nres + 3'd1;
      end
      if (call2 && o2.cnt == 2'd2 && nres < 3'd4) begin
         res[nres[1:0]] = o2.r1;
         nres = nres + 3'd1;
      end
      if (endf && oe.cnt == 2'd2 && nres < 3'd4) begin
         res[nres[1:0]] = oe.r0;
         nres = nres + 3'd1;
      end
      if (endf && nres < 3'd4) begin
         res[nres[1:0]] = oe.r1;
         nres = nres + 3'd1;
      end
      if (nres != 3'd0) res[2'(nres - 3'd1)].last_result = 1'b1;
   end

   always_comb begin
      lex_in   = endf ? lex_rst : s2;
      strip_in = endf ? csl_pkg::StripNormal : strip_mid;
      count_in = count_ff + (acc ? {1'b0, nres} : 4'd0) - {3'd0, pop};
   end

   assign req_ready = count_ff <= 4'(csl_pkg::FifoDepth - csl_pkg::MaxResults);
   assign rsp_valid = count_ff != 4'd0;
   assign rsp_data  = fifo_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_ff   <= lex_rst;
         strip_ff <= csl_pkg::StripNormal;
         soff_ff  <= '0;
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (acc) begin
            lex_ff   <= lex_in;
            strip_ff <= strip_in;
            soff_ff  <= endf ? 32'd0 : soff_in;
            wptr_ff  <= wptr_ff + nres;
         end
         if (pop) rptr_ff <= rptr_ff + 3'd1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         for (int i = 0; i < csl_pkg::MaxResults; i++) begin
            if (3'(i) < nres) fifo_ff[wptr_ff + 3'(i)] <= res[i];
         end
      end
   end

   `CSL_ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
                    count_ff <= 4'(csl_pkg::FifoDepth))
   `CSL_ASSERT_SAME(a_end_has_result, clock, reset, acc && endf, nres != 3'd0)
   `CSL_ASSERT_NEXT(a_end_resets, clock, reset, acc && endf,
                    soff_ff == 32'd0 && strip_ff == csl_pkg::StripNormal
                    && lex_ff.line == 16'd1)
   `CSL_ASSERT_NEXT(a_queue_fill, clock, reset, acc && !pop,
                    count_ff == $past(count_ff) + {1'b0, $past(nres)})

endmodule
